// ===== rtl/core/gcm_pkg.sv =====
package gcm_pkg;

   localparam int BLOCK_W = 128;
   localparam int HALF_W = 64;
   localparam int COUNT_W = 61;
   localparam int NBYTES_W = 5;
   localparam int OP_W = 2;
   localparam int CSR_INDEX_W = 2;
   localparam int BLOCK_BYTES = 16;

   localparam logic [OP_W-1:0] OP_AAD = 2'd0;
   localparam logic [OP_W-1:0] OP_TEXT = 2'd1;
   localparam logic [OP_W-1:0] OP_FINISH = 2'd2;
   localparam logic [OP_W-1:0] OP_NONE = 2'd3;

   localparam logic [CSR_INDEX_W-1:0] REG_HASH_KEY_HI = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_HASH_KEY_LO = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_DECRYPT_MODE = 2'd2;

   typedef struct packed {
      logic [BLOCK_W-1:0] hash_key;
      logic               decrypt_mode;
   } csr_type;

   typedef struct packed {
      logic [OP_W-1:0]     opcode;
      logic [BLOCK_W-1:0]  data;
      logic [BLOCK_W-1:0]  pad;
      logic [NBYTES_W-1:0] nbytes;
   } blk_type;

   typedef struct packed {
      logic valid;
      logic go;
   } stage_ctl_type;

   // GF(2^128) product in GCM bit order (block bit 127 is coefficient of x^0)
   function automatic logic [BLOCK_W-1:0] gf_mult(logic [BLOCK_W-1:0] x,
                                                  logic [BLOCK_W-1:0] y);
      logic [BLOCK_W-1:0]   a;
      logic [BLOCK_W-1:0]   b;
      logic [2*BLOCK_W-2:0] p;
      logic [BLOCK_W-2:0]   h;
      logic [BLOCK_W+5:0]   t;
      logic [5:0]           g;
      logic [BLOCK_W-1:0]   low;
      logic [BLOCK_W-1:0]   r;
      for (int i = 0; i < BLOCK_W; i++) begin
         a[i] = x[BLOCK_W-1-i];
         b[i] = y[BLOCK_W-1-i];
      end
      p = '0;
      for (int i = 0; i < BLOCK_W; i++) begin
         if (a[i]) begin
            p = p ^ ({127'b0, b} << i);
         end
      end
      h = p[2*BLOCK_W-2:BLOCK_W];
      t = {6'b0, p[BLOCK_W-1:0]} ^ {7'b0, h} ^ {6'b0, h, 1'b0}
        ^ ({7'b0, h} << 2) ^ ({7'b0, h} << 7);
      g = t[BLOCK_W+5:BLOCK_W];
      low = t[BLOCK_W-1:0] ^ {122'b0, g} ^ {121'b0, g, 1'b0}
          ^ {120'b0, g, 2'b0} ^ {115'b0, g, 7'b0};
      for (int i = 0; i < BLOCK_W; i++) begin
         r[i] = low[BLOCK_W-1-i];
      end
      return r;
   endfunction

endpackage

// ===== rtl/core/gcm_req_if.sv =====
interface gcm_req_if;
   import gcm_pkg::*;

   logic                valid;
   logic                ready;
   logic [OP_W-1:0]     opcode;
   logic [HALF_W-1:0]   data_hi;
   logic [HALF_W-1:0]   data_lo;
   logic [HALF_W-1:0]   pad_hi;
   logic [HALF_W-1:0]   pad_lo;
   logic [NBYTES_W-1:0] valid_bytes;

   modport source (output valid, opcode, data_hi, data_lo, pad_hi, pad_lo, valid_bytes,
                   input ready);
   modport sink (input valid, opcode, data_hi, data_lo, pad_hi, pad_lo, valid_bytes,
                 output ready);
endinterface

// ===== rtl/core/gcm_rsp_if.sv =====
interface gcm_rsp_if;
   import gcm_pkg::*;

   logic              valid;
   logic              ready;
   logic [HALF_W-1:0] result_hi;
   logic [HALF_W-1:0] result_lo;
   logic              is_tag;
   logic              tag_match;

   modport source (output valid, result_hi, result_lo, is_tag, tag_match, input ready);
   modport sink (input valid, result_hi, result_lo, is_tag, tag_match, output ready);
endinterface

// ===== rtl/core/gcm_csr.sv =====
module gcm_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_write_en,
   input  logic [gcm_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [gcm_pkg::HALF_W-1:0]      csr_wdata,
   output gcm_pkg::csr_type                csr_out
);
   import gcm_pkg::*;

   logic [HALF_W-1:0] key_hi_ff, key_hi_in;
   logic [HALF_W-1:0] key_lo_ff, key_lo_in;
   logic              decrypt_ff, decrypt_in;

   always_comb begin
      key_hi_in = key_hi_ff;
      key_lo_in = key_lo_ff;
      decrypt_in = decrypt_ff;
      if (csr_write_en) begin
         case (csr_index)
            REG_HASH_KEY_HI: key_hi_in = csr_wdata;
            REG_HASH_KEY_LO: key_lo_in = csr_wdata;
            REG_DECRYPT_MODE: decrypt_in = csr_wdata[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_hi_ff <= '0;
         key_lo_ff <= '0;
         decrypt_ff <= 1'b0;
      end else begin
         key_hi_ff <= key_hi_in;
         key_lo_ff <= key_lo_in;
         decrypt_ff <= decrypt_in;
      end
   end

   assign csr_out.hash_key = {key_hi_ff, key_lo_ff};
   assign csr_out.decrypt_mode = decrypt_ff;
endmodule

// ===== rtl/core/gcm_in_stage.sv =====
module gcm_in_stage (
   input  logic                   clock,
   input  logic                   reset,
   gcm_req_if.sink                req_bus,
   input  logic                   go,
   output logic                   blk_valid,
   output gcm_pkg::blk_type       blk
);
   import gcm_pkg::*;

   logic    valid_ff, valid_in;
   blk_type blk_ff, blk_in;
   logic    take;
   logic [NBYTES_W-1:0] nbytes_sat;

   assign req_bus.ready = !reset && (!valid_ff || go);
   assign take = req_bus.valid && req_bus.ready;
   assign nbytes_sat = (req_bus.valid_bytes > NBYTES_W'(BLOCK_BYTES))
                     ? NBYTES_W'(BLOCK_BYTES) : req_bus.valid_bytes;

   always_comb begin
      valid_in = valid_ff;
      blk_in = blk_ff;
      if (take) begin
         valid_in = 1'b1;
         blk_in.opcode = req_bus.opcode;
         blk_in.data = {req_bus.data_hi, req_bus.data_lo};
         blk_in.pad = {req_bus.pad_hi, req_bus.pad_lo};
         blk_in.nbytes = nbytes_sat;
      end else if (go) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      blk_ff <= blk_in;
   end

   assign blk_valid = valid_ff;
   assign blk = blk_ff;
endmodule

// ===== rtl/core/gcm_datapath.sv =====
module gcm_datapath (
   input  logic                   clock,
   input  logic                   reset,
   input  gcm_pkg::csr_type       csr_cfg,
   input  logic                   blk_valid,
   input  gcm_pkg::blk_type       blk,
   output gcm_pkg::stage_ctl_type ctl,
   gcm_rsp_if.source              rsp_bus
);
   import gcm_pkg::*;

   logic [BLOCK_W-1:0] acc_ff, acc_in;
   logic [COUNT_W-1:0] aad_cnt_ff, aad_cnt_in;
   logic [COUNT_W-1:0] text_cnt_ff, text_cnt_in;
   logic               out_valid_ff, out_valid_in;
   logic [BLOCK_W-1:0] out_data_ff, out_data_in;
   logic               out_tag_ff, out_tag_in;
   logic               out_match_ff, out_match_in;

   logic               go;
   logic [BLOCK_W-1:0] mask;
   logic [BLOCK_W-1:0] text_out;
   logic [BLOCK_W-1:0] fold_in;
   logic [BLOCK_W-1:0] prod;
   logic [BLOCK_W-1:0] tag;

   assign go = blk_valid && (!out_valid_ff || rsp_bus.ready);
   assign ctl.valid = blk_valid;
   assign ctl.go = go;

   always_comb begin
      for (int i = 0; i < BLOCK_BYTES; i++) begin
         mask[BLOCK_W-1-8*i -: 8] = (NBYTES_W'(i) < blk.nbytes) ? 8'hFF : 8'h00;
      end
   end

   assign text_out = (blk.data ^ blk.pad) & mask;

   always_comb begin
      case (blk.opcode)
         OP_AAD: fold_in = blk.data & mask;
         OP_TEXT: fold_in = csr_cfg.decrypt_mode ? (blk.data & mask) : text_out;
         OP_FINISH: fold_in = {aad_cnt_ff, 3'b000, text_cnt_ff, 3'b000};
         default: fold_in = '0;
      endcase
   end

   assign prod = gf_mult(acc_ff ^ fold_in, csr_cfg.hash_key);
   assign tag = prod ^ blk.data;

   always_comb begin
      acc_in = acc_ff;
      aad_cnt_in = aad_cnt_ff;
      text_cnt_in = text_cnt_ff;
      out_valid_in = out_valid_ff && !rsp_bus.ready;
      out_data_in = out_data_ff;
      out_tag_in = out_tag_ff;
      out_match_in = out_match_ff;
      if (go) begin
         case (blk.opcode)
            OP_AAD: begin
               acc_in = prod;
               aad_cnt_in = aad_cnt_ff + COUNT_W'(blk.nbytes);
            end
            OP_TEXT: begin
               acc_in = prod;
               text_cnt_in = text_cnt_ff + COUNT_W'(blk.nbytes);
               out_valid_in = 1'b1;
               out_data_in = text_out;
               out_tag_in = 1'b0;
               out_match_in = 1'b0;
            end
            OP_FINISH: begin
               acc_in = '0;
               aad_cnt_in = '0;
               text_cnt_in = '0;
               out_valid_in = 1'b1;
               out_data_in = tag;
               out_tag_in = 1'b1;
               out_match_in = (tag == blk.pad);
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
         aad_cnt_ff <= '0;
         text_cnt_ff <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         acc_ff <= acc_in;
         aad_cnt_ff <= aad_cnt_in;
         text_cnt_ff <= text_cnt_in;
         out_valid_ff <= out_valid_in;
      end
      out_data_ff <= out_data_in;
      out_tag_ff <= out_tag_in;
      out_match_ff <= out_match_in;
   end

   assign rsp_bus.valid = out_valid_ff;
   assign rsp_bus.result_hi = out_data_ff[BLOCK_W-1:HALF_W];
   assign rsp_bus.result_lo = out_data_ff[HALF_W-1:0];
   assign rsp_bus.is_tag = out_tag_ff;
   assign rsp_bus.tag_match = out_match_ff;

   a_finish_clears: assert property (@(posedge clock) disable iff (reset)
      go && blk.opcode == OP_FINISH |=> acc_ff == '0 && aad_cnt_ff == '0 && text_cnt_ff == '0)
      else $error("state not cleared after finish");

   a_unused_holds: assert property (@(posedge clock) disable iff (reset)
      go && blk.opcode == OP_NONE |=> $stable(acc_ff) && $stable(aad_cnt_ff)
      && $stable(text_cnt_ff))
      else $error("unused opcode changed state");

   a_aad_no_result: assert property (@(posedge clock) disable iff (reset)
      go && blk.opcode == OP_AAD && !out_valid_ff |=> !out_valid_ff)
      else $error("associated data produced a result");

   a_match_only_tag: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !out_tag_ff |-> !out_match_ff)
      else $error("tag match flagged on text result");
endmodule

// ===== rtl/core/gcm_ghash_ctr_engine.sv =====
// GCM data path: GHASH accumulator plus counter-mode XOR around an external cipher.
// One item is accepted every cycle while the result output is not stalled; a text or
// finish result passes through the input register, then the result register. The pace
// is set by the GF(2^128) multiplier in the accumulator feedback loop. Associated-data
// beats produce no result; a finish beat returns the tag with a match flag and clears
// the accumulator and byte counts. Write the hash key and mode only while idle.
module gcm_ghash_ctr_engine (
   input  logic                            clock,
   input  logic                            reset,
   gcm_req_if.sink                         req_bus,
   gcm_rsp_if.source                       rsp_bus,
   input  logic                            csr_write_en,
   input  logic [gcm_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [gcm_pkg::HALF_W-1:0]      csr_wdata
);
   import gcm_pkg::*;

   csr_type       csr_cfg;
   blk_type       blk;
   logic          blk_valid;
   stage_ctl_type ctl;

   gcm_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .csr_out      (csr_cfg)
   );

   gcm_in_stage u_in_stage (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .go        (ctl.go),
      .blk_valid (blk_valid),
      .blk       (blk)
   );

   gcm_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .csr_cfg   (csr_cfg),
      .blk_valid (blk_valid),
      .blk       (blk),
      .ctl       (ctl),
      .rsp_bus   (rsp_bus)
   );

   a_go_needs_valid: assert property (@(posedge clock) disable iff (reset)
      ctl.go |-> ctl.valid)
      else $error("stage advanced without a held beat");

   a_hold_when_blocked: assert property (@(posedge clock) disable iff (reset)
      ctl.valid && !ctl.go |=> ctl.valid && $stable(blk))
      else $error("held beat lost while blocked");

   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !ctl.valid |-> req_bus.ready)
      else $error("input not ready while stage empty");
endmodule

// ===== tb/tb_top.sv =====
module tb_top;
   import gcm_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int SETTLE_CYCLES = 6;
   localparam int RANDOM_BEATS = 400;
   localparam int TOTAL_BEATS = 460;
   localparam logic [BLOCK_W-1:0] ALL_ONES = {BLOCK_W{1'b1}};
   localparam logic [BLOCK_W-1:0] GF_ONE = {1'b1, {(BLOCK_W-1){1'b0}}};

   typedef struct {
      logic [BLOCK_W-1:0] block;
      logic               is_tag;
      logic               tag_match;
   } out_block_type;

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   csr_write_en;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [HALF_W-1:0]      csr_wdata;

   gcm_req_if req_bus ();
   gcm_rsp_if rsp_bus ();

   gcm_ghash_ctr_engine u_top (
      .clock        (clock),
      .reset        (reset),
      .req_bus      (req_bus),
      .rsp_bus      (rsp_bus),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   logic [BLOCK_W-1:0] hash_key;
   logic               decrypt;
   logic [BLOCK_W-1:0] ghash_acc;
   logic [COUNT_W-1:0] aad_bytes;
   logic [COUNT_W-1:0] text_bytes;

   out_block_type out_blocks_due[$];

   int  errors = 0;
   int  req_beats = 0;
   int  rsp_beats = 0;
   int  aad_beats = 0;
   int  text_beats = 0;
   int  finish_beats = 0;
   int  unused_beats = 0;
   int  tags_matched = 0;
   int  key_settings = 0;
   int  quiet_cycles = 0;
   bit  idle_on = 1'b1;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic logic [BLOCK_W-1:0] ghash_mul(logic [BLOCK_W-1:0] x,
                                                    logic [BLOCK_W-1:0] y);
      logic [BLOCK_W-1:0] z;
      logic [BLOCK_W-1:0] v;
      z = '0;
      v = y;
      for (int i = BLOCK_W - 1; i >= 0; i--) begin
         if (x[i]) begin
            z = z ^ v;
         end
         if (v[0]) begin
            v = (v >> 1) ^ {8'he1, 120'b0};
         end else begin
            v = v >> 1;
         end
      end
      return z;
   endfunction

   function automatic int sat_bytes(logic [NBYTES_W-1:0] nb);
      return (nb > BLOCK_BYTES) ? BLOCK_BYTES : int'(nb);
   endfunction

   function automatic logic [BLOCK_W-1:0] byte_mask(int n);
      logic [BLOCK_W-1:0] m;
      m = '0;
      if (n > 0) begin
         m = ALL_ONES << (BLOCK_W - 8 * n);
      end
      return m;
   endfunction

   // tag that a finish beat with this encrypted J0 would produce right now
   function automatic logic [BLOCK_W-1:0] finish_tag(logic [BLOCK_W-1:0] j0);
      return ghash_mul(ghash_acc ^ {aad_bytes, 3'b0, text_bytes, 3'b0}, hash_key) ^ j0;
   endfunction

   function automatic logic [BLOCK_W-1:0] rand_block();
      return {$urandom, $urandom, $urandom, $urandom};
   endfunction

   task automatic advance_gcm(logic [OP_W-1:0] op, logic [BLOCK_W-1:0] data,
                              logic [BLOCK_W-1:0] pad, logic [NBYTES_W-1:0] nb);
      out_block_type      beat;
      logic [BLOCK_W-1:0] m;
      int                 n;
      n = sat_bytes(nb);
      m = byte_mask(n);
      case (op)
         OP_AAD: begin
            ghash_acc = ghash_mul(ghash_acc ^ (data & m), hash_key);
            aad_bytes = aad_bytes + COUNT_W'(n);
            aad_beats++;
         end
         OP_TEXT: begin
            beat.block = (data ^ pad) & m;
            beat.is_tag = 1'b0;
            beat.tag_match = 1'b0;
            ghash_acc = ghash_mul(ghash_acc ^ (decrypt ? (data & m) : beat.block), hash_key);
            text_bytes = text_bytes + COUNT_W'(n);
            out_blocks_due.push_back(beat);
            text_beats++;
         end
         OP_FINISH: begin
            beat.block = finish_tag(data);
            beat.is_tag = 1'b1;
            beat.tag_match = (beat.block == pad);
            if (beat.tag_match) begin
               tags_matched++;
            end
            ghash_acc = '0;
            aad_bytes = '0;
            text_bytes = '0;
            out_blocks_due.push_back(beat);
            finish_beats++;
         end
         default: begin
            unused_beats++;
         end
      endcase
   endtask

   task automatic send_block(logic [OP_W-1:0] op, logic [BLOCK_W-1:0] data,
                             logic [BLOCK_W-1:0] pad, logic [NBYTES_W-1:0] nb);
      if (idle_on && $urandom_range(0, 5) == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 15)) @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.opcode <= op;
      req_bus.data_hi <= data[BLOCK_W-1:HALF_W];
      req_bus.data_lo <= data[HALF_W-1:0];
      req_bus.pad_hi <= pad[BLOCK_W-1:HALF_W];
      req_bus.pad_lo <= pad[HALF_W-1:0];
      req_bus.valid_bytes <= nb;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      req_beats++;
      advance_gcm(op, data, pad, nb);
   endtask

   // drop valid, wait for every result, then let the pipeline empty
   task automatic drain();
      req_bus.valid <= 1'b0;
      while (out_blocks_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic program_regs(logic [BLOCK_W-1:0] key, logic mode);
      csr_write_en <= 1'b1;
      csr_index <= REG_HASH_KEY_HI;
      csr_wdata <= key[BLOCK_W-1:HALF_W];
      @(posedge clock);
      csr_index <= REG_HASH_KEY_LO;
      csr_wdata <= key[HALF_W-1:0];
      @(posedge clock);
      csr_index <= REG_DECRYPT_MODE;
      csr_wdata <= HALF_W'(mode);
      @(posedge clock);
      csr_write_en <= 1'b0;
      hash_key = key;
      decrypt = mode;
      key_settings++;
   endtask

   task automatic send_message(int n_aad, int n_text, bit good_tag);
      logic [BLOCK_W-1:0]  j0;
      logic [BLOCK_W-1:0]  tag;
      logic [NBYTES_W-1:0] nb;
      for (int i = 0; i < n_aad; i++) begin
         nb = (i == n_aad - 1) ? NBYTES_W'($urandom_range(1, 16)) : NBYTES_W'(BLOCK_BYTES);
         send_block(OP_AAD, rand_block(), rand_block(), nb);
      end
      for (int i = 0; i < n_text; i++) begin
         nb = (i == n_text - 1) ? NBYTES_W'($urandom_range(1, 16)) : NBYTES_W'(BLOCK_BYTES);
         send_block(OP_TEXT, rand_block(), rand_block(), nb);
      end
      j0 = rand_block();
      tag = finish_tag(j0);
      if (!good_tag) begin
         tag[$urandom_range(0, BLOCK_W - 1)] ^= 1'b1;
      end
      send_block(OP_FINISH, j0, tag, NBYTES_W'($urandom));
   endtask

   task automatic send_noise();
      send_block(OP_W'($urandom_range(0, 3)), rand_block(), rand_block(),
                 NBYTES_W'($urandom_range(0, 31)));
   endtask

   task automatic test_directed();
      program_regs(128'h66e94bd4ef8a2c3b884cfa59ca342b2e, 1'b0);
      send_block(OP_FINISH, '0, finish_tag('0), NBYTES_W'(BLOCK_BYTES));
      send_block(OP_AAD, ALL_ONES, '0, NBYTES_W'(16));
      send_block(OP_AAD, ALL_ONES, '0, NBYTES_W'(1));
      send_block(OP_AAD, ALL_ONES, ALL_ONES, NBYTES_W'(0));
      send_block(OP_AAD, rand_block(), '0, NBYTES_W'(31));
      send_block(OP_TEXT, ALL_ONES, '0, NBYTES_W'(16));
      send_block(OP_TEXT, rand_block(), rand_block(), NBYTES_W'(1));
      send_block(OP_TEXT, rand_block(), rand_block(), NBYTES_W'(8));
      send_block(OP_TEXT, rand_block(), rand_block(), NBYTES_W'(9));
      send_block(OP_TEXT, rand_block(), rand_block(), NBYTES_W'(0));
      send_block(OP_TEXT, ALL_ONES, ALL_ONES, NBYTES_W'(17));
      send_block(OP_NONE, ALL_ONES, ALL_ONES, NBYTES_W'(16));
      send_block(OP_AAD, rand_block(), rand_block(), NBYTES_W'(15));
      send_block(OP_FINISH, ALL_ONES, finish_tag(ALL_ONES), NBYTES_W'(0));
      send_block(OP_FINISH, rand_block(), rand_block(), NBYTES_W'(31));
      drain();
      program_regs(rand_block(), 1'b1);
      send_block(OP_TEXT, rand_block(), rand_block(), NBYTES_W'(16));
      send_block(OP_TEXT, '0, ALL_ONES, NBYTES_W'(5));
      send_block(OP_AAD, rand_block(), rand_block(), NBYTES_W'(16));
      send_block(OP_FINISH, rand_block(), ALL_ONES, NBYTES_W'(16));
      drain();
   endtask

   task automatic test_key_extremes();
      logic [BLOCK_W-1:0] keys [4];
      keys[0] = '0;
      keys[1] = ALL_ONES;
      keys[2] = GF_ONE;
      keys[3] = rand_block();
      for (int k = 0; k < 4; k++) begin
         for (int mode = 0; mode < 2; mode++) begin
            program_regs(keys[k], mode[0]);
            send_message(2, 3, 1'b1);
            send_message(0, 1, 1'b0);
            drain();
         end
      end
   endtask

   task automatic test_random_traffic();
      int mark;
      mark = req_beats;
      program_regs(rand_block(), 1'($urandom));
      while (req_beats < RANDOM_BEATS) begin
         if (req_beats - mark > 60) begin
            drain();
            case ($urandom_range(0, 5))
               0: program_regs('0, 1'($urandom));
               1: program_regs(ALL_ONES, 1'($urandom));
               default: program_regs(rand_block(), 1'($urandom));
            endcase
            mark = req_beats;
         end
         if ($urandom_range(0, 9) < 2) begin
            send_noise();
         end else begin
            send_message($urandom_range(0, 3), $urandom_range(0, 6), 1'($urandom));
         end
      end
      drain();
   endtask

   task automatic test_back_to_back();
      idle_on = 1'b0;
      program_regs(rand_block(), 1'($urandom));
      while (req_beats < TOTAL_BEATS) begin
         send_message($urandom_range(0, 2), $urandom_range(1, 4), 1'($urandom));
      end
      drain();
   endtask

   initial begin
      int stall;
      stall = 0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (stall > 0) begin
            stall--;
            rsp_bus.ready <= 1'b0;
         end else if (idle_on && $urandom_range(0, 9) == 0) begin
            stall = $urandom_range(1, 15) - 1;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin : check_results
      out_block_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         rsp_beats++;
         if (out_blocks_due.size() == 0) begin
            $display("%0t unexpected result beat: actual %h_%h is_tag %b tag_match %b",
                     $time, rsp_bus.result_hi, rsp_bus.result_lo, rsp_bus.is_tag,
                     rsp_bus.tag_match);
            errors++;
         end else begin
            want = out_blocks_due.pop_front();
            if (rsp_bus.result_hi !== want.block[BLOCK_W-1:HALF_W]) begin
               $display("%0t result_hi expected %h actual %h", $time,
                        want.block[BLOCK_W-1:HALF_W], rsp_bus.result_hi);
               errors++;
            end
            if (rsp_bus.result_lo !== want.block[HALF_W-1:0]) begin
               $display("%0t result_lo expected %h actual %h", $time,
                        want.block[HALF_W-1:0], rsp_bus.result_lo);
               errors++;
            end
            if (rsp_bus.is_tag !== want.is_tag) begin
               $display("%0t is_tag expected %b actual %b", $time, want.is_tag,
                        rsp_bus.is_tag);
               errors++;
            end
            if (rsp_bus.tag_match !== want.tag_match) begin
               $display("%0t tag_match expected %b actual %b", $time, want.tag_match,
                        rsp_bus.tag_match);
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin : watchdog
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)
          || csr_write_en) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t watchdog: no beat for %0d cycles, %0d results outstanding",
                  $time, quiet_cycles, out_blocks_due.size());
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   initial begin
      reset <= 1'b1;
      csr_write_en <= 1'b0;
      csr_index <= REG_HASH_KEY_HI;
      csr_wdata <= '0;
      req_bus.valid <= 1'b0;
      req_bus.opcode <= OP_NONE;
      req_bus.data_hi <= '0;
      req_bus.data_lo <= '0;
      req_bus.pad_hi <= '0;
      req_bus.pad_lo <= '0;
      req_bus.valid_bytes <= '0;
      hash_key = '0;
      decrypt = 1'b0;
      ghash_acc = '0;
      aad_bytes = '0;
      text_bytes = '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_key_extremes();
      test_random_traffic();
      test_back_to_back();
      if (out_blocks_due.size() != 0) begin
         $display("%0t %0d expected results never arrived", $time, out_blocks_due.size());
         errors++;
      end
      $display("Covered %0d request beats (%0d AAD, %0d text, %0d finish, %0d unused), %0d results.",
               req_beats, aad_beats, text_beats, finish_beats, unused_beats, rsp_beats);
      $display("%0d key/mode settings, %0d tags matched, %0d mismatches.",
               key_settings, tags_matched, errors);
      if (errors == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/core/gcm_pkg.sv
rtl/core/gcm_req_if.sv
rtl/core/gcm_rsp_if.sv
rtl/core/gcm_csr.sv
rtl/core/gcm_in_stage.sv
rtl/core/gcm_datapath.sv
rtl/core/gcm_ghash_ctr_engine.sv
tb/tb_top.sv
